/* rtl/core/gb9_pkg.sv */
// ============================================================================
// gb9_pkg
// Shared types, constants and helper functions for the 9x9 Gaussian blur
// stream core: pixel and column types, kernel weights, FSM states and the
// control and status bundles between the core and its arithmetic unit.
// ============================================================================
package gb9_pkg;

   // Window geometry
   localparam int TAPS       = 9;
   localparam int STORE_ROWS = 8;
   localparam int SLOT_W     = 3;
   localparam int TAP_W      = 4;

   // Field widths
   localparam int PIXEL_W  = 8;
   localparam int COEF_W   = 8;
   localparam int NUM_COEF = 5;
   localparam int WIDTH_W  = 10;
   localparam int HEIGHT_W = 13;
   localparam int ROW_W    = 12;

   // Frame height limit
   localparam int MAX_HEIGHT = 4096;

   // Arithmetic widths: 8x8 product, sum of nine products, weighted column sum
   localparam int PROD_W    = 16;
   localparam int VSUM_W    = 20;
   localparam int HPROD_W   = 28;
   localparam int ACC_W     = 32;
   localparam int OUT_SHIFT = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   typedef logic [PIXEL_W-1:0]                  pixel_type;
   typedef logic [TAPS-1:0][PIXEL_W-1:0]        column_type;
   typedef logic [STORE_ROWS-1:0][PIXEL_W-1:0]  store_word_type;
   typedef logic [COEF_W-1:0]                   coef_type;
   typedef logic [NUM_COEF-1:0][COEF_W-1:0]     coef_set_type;
   typedef logic [TAP_W-1:0]                    tap_type;
   typedef logic [PROD_W-1:0]                   prod_type;
   typedef logic [VSUM_W-1:0]                   vsum_type;
   typedef logic [HPROD_W-1:0]                  hprod_type;
   typedef logic [ACC_W-1:0]                    acc_type;
   typedef logic [ROW_W-1:0]                    row_type;
   typedef logic [SLOT_W-1:0]                   slot_type;

   localparam tap_type LAST_TAP = tap_type'(TAPS - 1);

   // Register reset values; entry k is the weight at distance k from center
   localparam coef_set_type COEF_RESET = {8'd1, 8'd9, 8'd27, 8'd54, 8'd67};
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd480;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd640;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_CENTER  = 3'd0,
      CSR_COEF_OFF1    = 3'd1,
      CSR_COEF_OFF2    = 3'd2,
      CSR_COEF_OFF3    = 3'd3,
      CSR_COEF_OFF4    = 3'd4,
      CSR_IMAGE_WIDTH  = 3'd5,
      CSR_IMAGE_HEIGHT = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_EMIT
   } state_type;

   // Control from the sequencer to the arithmetic unit
   typedef struct packed {
      logic    clear;
      logic    start;
      tap_type tap;
   } mac_ctrl_type;

   // Status from the arithmetic unit
   typedef struct packed {
      logic      busy;
      pixel_type result;
   } mac_stat_type;

   // Weight of a tap position 0..8, symmetric around the center tap.
   function automatic coef_type tap_weight(input coef_set_type coefs, input tap_type pos);
      coef_type w;
      unique case (pos)
         4'd0, 4'd8: w = coefs[4];
         4'd1, 4'd7: w = coefs[3];
         4'd2, 4'd6: w = coefs[2];
         4'd3, 4'd5: w = coefs[1];
         4'd4:       w = coefs[0];
         default:    w = '0;
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/gb9_ifs.sv */
// ============================================================================
// gb9_ifs
// Valid/ready channel interfaces of the blur core: pixel input, blurred
// pixel output and the register write port.
// ============================================================================

// Input pixel channel
interface gb9_req_if;
   logic                valid;
   logic                ready;
   gb9_pkg::pixel_type  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

// Blurred pixel channel
interface gb9_rsp_if;
   logic                valid;
   logic                ready;
   gb9_pkg::pixel_type  pixel_out;
   logic                end_of_frame;

   modport source (output valid, output pixel_out, output end_of_frame, input ready);
   modport sink   (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

// Register write channel
interface gb9_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gb9_pkg::CSR_INDEX_W-1:0]     index;
   logic [gb9_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/gb9_cell.sv */
// ============================================================================
// gb9_cell
// One column cell of the window chain. It holds nine pixels of one window
// column and takes the column of its neighbor when the chain shifts.
// ============================================================================
module gb9_cell (
   input  logic                 clock,
   input  logic                 shift_en,
   input  gb9_pkg::column_type  col_in,
   output gb9_pkg::column_type  col_out
);

   gb9_pkg::column_type col_ff;
   gb9_pkg::column_type col_in_mux;

   // Hold the column unless the chain moves.
   assign col_in_mux = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in_mux;
   end

   assign col_out = col_ff;

endmodule

/* rtl/core/gb9_line_store.sv */
// ============================================================================
// gb9_line_store
// Row buffer for the last eight input rows. One word per column position
// holds the eight stored rows of that column; one read and one write port,
// read data registered.
// ============================================================================
module gb9_line_store #(
   parameter int ADDR_W = 9
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  gb9_pkg::store_word_type  wr_data,
   output gb9_pkg::store_word_type  rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   gb9_pkg::store_word_type row_mem_ff [DEPTH];
   gb9_pkg::store_word_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/gb9_mac.sv */
// ============================================================================
// gb9_mac
// Weighted window sum. Each started step takes one window column, weights
// its nine pixels with the vertical taps, adds them, weights the column sum
// with the horizontal tap and accumulates. Three register stages.
// ============================================================================
module gb9_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  gb9_pkg::mac_ctrl_type  ctrl,
   input  gb9_pkg::coef_set_type  coefs,
   input  gb9_pkg::column_type    col,
   output gb9_pkg::mac_stat_type  stat
);

   gb9_pkg::prod_type  prod_in [gb9_pkg::TAPS];
   gb9_pkg::prod_type  prod_ff [gb9_pkg::TAPS];
   logic               p_valid_ff;
   gb9_pkg::tap_type   p_tap_ff;

   gb9_pkg::vsum_type  vsum_in;
   gb9_pkg::vsum_type  vsum_ff;
   logic               v_valid_ff;
   gb9_pkg::tap_type   v_tap_ff;

   gb9_pkg::hprod_type hprod;
   gb9_pkg::acc_type   acc_in;
   gb9_pkg::acc_type   acc_ff;

   // Vertical weighting of the column, one product per row.
   always_comb begin
      for (int r = 0; r < gb9_pkg::TAPS; r++) begin
         prod_in[r] = gb9_pkg::prod_type'(col[r]) *
                      gb9_pkg::prod_type'(gb9_pkg::tap_weight(coefs,
                                                              gb9_pkg::tap_type'(r)));
      end
   end

   // Sum of the nine row products.
   always_comb begin
      vsum_in = '0;
      for (int r = 0; r < gb9_pkg::TAPS; r++) begin
         vsum_in = vsum_in + gb9_pkg::vsum_type'(prod_ff[r]);
      end
   end

   // Horizontal weighting and accumulation; the sum wraps at 32 bits.
   assign hprod  = gb9_pkg::hprod_type'(vsum_ff) *
                   gb9_pkg::hprod_type'(gb9_pkg::tap_weight(coefs, v_tap_ff));
   assign acc_in = acc_ff + gb9_pkg::acc_type'(hprod);

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         v_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= ctrl.start;
         v_valid_ff <= p_valid_ff;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         prod_ff  <= prod_in;
         p_tap_ff <= ctrl.tap;
      end
      if (p_valid_ff) begin
         vsum_ff  <= vsum_in;
         v_tap_ff <= p_tap_ff;
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (v_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign stat.busy   = p_valid_ff | v_valid_ff;
   assign stat.result = acc_ff[gb9_pkg::OUT_SHIFT +: gb9_pkg::PIXEL_W];

endmodule

/* rtl/core/gaussian_blur_9x9_stream_core.sv */
// ============================================================================
// gaussian_blur_9x9_stream_core
// Direct 9x9 Gaussian blur over an 8-bit grayscale raster stream. A row
// buffer supplies the eight older rows of each column, a chain of nine
// column cells holds the window, and one weighting unit walks the window.
// ============================================================================
//
//  Channel   Dir  Beat payload                 Accepted when
//  --------  ---  ---------------------------  -------------------------
//  req_bus   in   pixel_in                     req_bus.valid & req_bus.ready
//  rsp_bus   out  pixel_out, end_of_frame      rsp_bus.valid & rsp_bus.ready
//  csr_bus   in   index, data                  csr_bus.valid & csr_bus.ready
//
//  A pixel that yields no output passes accept and the row buffer access.
//  One that yields an output then takes nine column steps through the
//  weighting unit, waits for its pipeline to drain and loads the output
//  register. The single weighting unit sets the pace: no new pixel is taken
//  until the last is through. The output register holds a beat while the
//  next pixel is taken; a stalled output holds the core only when it has
//  a new beat. Reset is synchronous and needs no clearing pass.
//
module gaussian_blur_9x9_stream_core #(
   parameter int MAX_WIDTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   gb9_req_if.sink     req_bus,
   gb9_rsp_if.source   rsp_bus,
   gb9_csr_if.sink     csr_bus
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int GEO_W = (COL_W + 1 > gb9_pkg::WIDTH_W) ? COL_W + 1 : gb9_pkg::WIDTH_W;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [GEO_W-1:0] geo_type;

   // Configuration registers
   gb9_pkg::coef_set_type             coef_ff;
   logic [gb9_pkg::WIDTH_W-1:0]       width_ff;
   logic [gb9_pkg::HEIGHT_W-1:0]      height_ff;

   // Sequencer
   gb9_pkg::state_type  state_ff, state_in;
   gb9_pkg::tap_type    step_ff, step_in;
   logic                accept;
   logic                rd_en;
   logic                wr_en;
   logic                cell_shift;
   logic                load_col;
   logic                rsp_load;
   gb9_pkg::mac_ctrl_type mac_ctrl;
   gb9_pkg::mac_stat_type mac_stat;

   // Position counters
   col_type             col_ff, col_in;
   gb9_pkg::row_type    row_ff, row_in;
   geo_type             col_ext;
   geo_type             wlast;
   geo_type             width_ext;
   gb9_pkg::row_type    hlast;
   logic                row_end;
   logic                frame_end;

   // Per-pixel capture
   gb9_pkg::pixel_type  pix_ff;
   gb9_pkg::slot_type   slot_ff;
   col_type             addr_ff;
   logic                emit_ff;
   logic                eof_ff;

   // Row buffer and window chain
   gb9_pkg::store_word_type rd_word;
   gb9_pkg::store_word_type new_word;
   gb9_pkg::column_type     new_col;
   gb9_pkg::column_type     cell_in  [gb9_pkg::TAPS];
   gb9_pkg::column_type     cell_out [gb9_pkg::TAPS];

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   gb9_pkg::pixel_type  rsp_pixel_ff;
   logic                rsp_eof_ff;

   // ------------------------------------------------------------------
   // Register writes
   // ------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= gb9_pkg::COEF_RESET;
         width_ff  <= gb9_pkg::WIDTH_RESET;
         height_ff <= gb9_pkg::HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         unique case (gb9_pkg::csr_index_type'(csr_bus.index))
            gb9_pkg::CSR_COEF_CENTER:  coef_ff[0] <= csr_bus.data[gb9_pkg::COEF_W-1:0];
            gb9_pkg::CSR_COEF_OFF1:    coef_ff[1] <= csr_bus.data[gb9_pkg::COEF_W-1:0];
            gb9_pkg::CSR_COEF_OFF2:    coef_ff[2] <= csr_bus.data[gb9_pkg::COEF_W-1:0];
            gb9_pkg::CSR_COEF_OFF3:    coef_ff[3] <= csr_bus.data[gb9_pkg::COEF_W-1:0];
            gb9_pkg::CSR_COEF_OFF4:    coef_ff[4] <= csr_bus.data[gb9_pkg::COEF_W-1:0];
            gb9_pkg::CSR_IMAGE_WIDTH:  width_ff   <= csr_bus.data[gb9_pkg::WIDTH_W-1:0];
            gb9_pkg::CSR_IMAGE_HEIGHT: height_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Effective geometry: last column and last row, saturated to range
   // ------------------------------------------------------------------
   assign width_ext = geo_type'(width_ff);
   assign col_ext   = geo_type'(col_ff);

   always_comb begin
      if (width_ext < geo_type'(gb9_pkg::TAPS)) begin
         wlast = geo_type'(gb9_pkg::TAPS - 1);
      end else if (width_ext > geo_type'(MAX_WIDTH)) begin
         wlast = geo_type'(MAX_WIDTH - 1);
      end else begin
         wlast = width_ext - geo_type'(1);
      end
   end

   always_comb begin
      if (height_ff < gb9_pkg::HEIGHT_W'(gb9_pkg::TAPS)) begin
         hlast = gb9_pkg::row_type'(gb9_pkg::TAPS - 1);
      end else if (height_ff > gb9_pkg::HEIGHT_W'(gb9_pkg::MAX_HEIGHT)) begin
         hlast = gb9_pkg::row_type'(gb9_pkg::MAX_HEIGHT - 1);
      end else begin
         hlast = gb9_pkg::row_type'(height_ff - gb9_pkg::HEIGHT_W'(1));
      end
   end

   assign row_end   = (col_ext >= wlast);
   assign frame_end = (row_ff >= hlast);

   // ------------------------------------------------------------------
   // Position counters, advanced on every accepted beat
   // ------------------------------------------------------------------
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + gb9_pkg::row_type'(1);
         end else begin
            col_in = col_ff + col_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Capture the pixel and its place in the frame.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req_bus.pixel_in;
         slot_ff <= row_ff[gb9_pkg::SLOT_W-1:0];
         addr_ff <= col_ff;
         emit_ff <= (row_ff >= gb9_pkg::row_type'(gb9_pkg::TAPS - 1)) &&
                    (col_ext >= geo_type'(gb9_pkg::TAPS - 1));
         eof_ff  <= frame_end && row_end;
      end
   end

   // ------------------------------------------------------------------
   // Row buffer: read the column, replace the oldest row with the pixel
   // ------------------------------------------------------------------
   gb9_line_store #(
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (col_ff),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (new_word),
      .rd_data (rd_word)
   );

   // The slot of the current row holds the oldest row until it is rewritten.
   always_comb begin
      for (int b = 0; b < gb9_pkg::STORE_ROWS; b++) begin
         new_word[b] = (slot_ff == gb9_pkg::slot_type'(b)) ? pix_ff : rd_word[b];
         new_col[b]  = rd_word[slot_ff + gb9_pkg::slot_type'(b)];
      end
      new_col[gb9_pkg::TAPS-1] = pix_ff;
   end

   // ------------------------------------------------------------------
   // Window chain: shifts in the new column, then rotates once around
   // ------------------------------------------------------------------
   for (genvar c = 0; c < gb9_pkg::TAPS; c++) begin : g_cell
      if (c == gb9_pkg::TAPS - 1) begin : g_tail
         assign cell_in[c] = load_col ? new_col : cell_out[0];
      end else begin : g_link
         assign cell_in[c] = cell_out[c+1];
      end

      gb9_cell u_cell (
         .clock    (clock),
         .shift_en (cell_shift),
         .col_in   (cell_in[c]),
         .col_out  (cell_out[c])
      );
   end

   gb9_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coefs (coef_ff),
      .col   (cell_out[0]),
      .stat  (mac_stat)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gb9_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      cell_shift    = 1'b0;
      load_col      = 1'b0;
      rsp_load      = 1'b0;
      mac_ctrl      = '0;
      unique case (state_ff)
         gb9_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            rd_en         = req_bus.valid;
            if (req_bus.valid) begin
               state_in = gb9_pkg::ST_LOAD;
            end
         end
         gb9_pkg::ST_LOAD: begin
            wr_en          = 1'b1;
            cell_shift     = 1'b1;
            load_col       = 1'b1;
            mac_ctrl.clear = 1'b1;
            step_in        = '0;
            state_in       = emit_ff ? gb9_pkg::ST_SUM : gb9_pkg::ST_IDLE;
         end
         gb9_pkg::ST_SUM: begin
            cell_shift     = 1'b1;
            mac_ctrl.start = 1'b1;
            mac_ctrl.tap   = step_ff;
            if (step_ff == gb9_pkg::LAST_TAP) begin
               state_in = gb9_pkg::ST_EMIT;
            end else begin
               step_in = step_ff + gb9_pkg::tap_type'(1);
            end
         end
         gb9_pkg::ST_EMIT: begin
            if (!mac_stat.busy && (!rsp_valid_ff || rsp_bus.ready)) begin
               rsp_load = 1'b1;
               state_in = gb9_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= mac_stat.result;
         rsp_eof_ff   <= eof_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_out    = rsp_pixel_ff;
   assign rsp_bus.end_of_frame = rsp_eof_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef SYNTH
   // An accepted beat always goes to the row buffer access next.
   a_load_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == gb9_pkg::ST_LOAD)
      else $error("accepted beat did not enter the load step");

   // The last column step hands over to the output step.
   a_sum_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gb9_pkg::ST_SUM && step_ff == gb9_pkg::LAST_TAP)
      |=> state_ff == gb9_pkg::ST_EMIT)
      else $error("column steps did not end after the last tap");

   // The weighting unit is drained whenever a new beat may enter.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == gb9_pkg::ST_IDLE |-> !mac_stat.busy)
      else $error("weighting unit still busy while idle");

   // A finished sum always lands in the output register.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == gb9_pkg::ST_IDLE)
      else $error("finished result not presented");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the 9x9 Gaussian blur stream core. Pixel frames
// of many shapes go in through the request channel while the result channel
// stalls at random. A scoreboard keeps its own line store and window, works
// out each blurred beat as pixels are accepted and compares each result
// beat field by field in order.
// ============================================================================
module tb;

   localparam int HALF_PERIOD    = 6;
   localparam int MAX_W          = 512;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PIXELS  = 150;
   localparam int REPORT_LIMIT   = 10;

   // Index that maps to no register; writes to it must change nothing.
   localparam logic [gb9_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef enum {PAT_RANDOM, PAT_ZERO, PAT_MAX, PAT_CHECKER, PAT_SPARSE} pattern_type;

   typedef struct {
      gb9_pkg::pixel_type pix;
      logic               eof;
   } blur_beat_type;

   // Predicts blurred beats from accepted pixels and checks result beats.
   class blur_scoreboard;
      bit [gb9_pkg::COEF_W-1:0]   weight[gb9_pkg::NUM_COEF];
      bit [gb9_pkg::WIDTH_W-1:0]  width_reg;
      bit [gb9_pkg::HEIGHT_W-1:0] height_reg;
      bit [gb9_pkg::PIXEL_W-1:0]  line_mem[gb9_pkg::STORE_ROWS][MAX_W];
      bit [gb9_pkg::PIXEL_W-1:0]  win[gb9_pkg::TAPS][gb9_pkg::TAPS];
      int unsigned                col;
      int unsigned                row;
      blur_beat_type              expected_q[$];
      int                         mismatches;
      int                         beats;

      function new();
         for (int k = 0; k < gb9_pkg::NUM_COEF; k++) weight[k] = gb9_pkg::COEF_RESET[k];
         width_reg  = gb9_pkg::WIDTH_RESET;
         height_reg = gb9_pkg::HEIGHT_RESET;
      endfunction

      function int unsigned eff_width();
         if (width_reg < gb9_pkg::TAPS) return gb9_pkg::TAPS;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg < gb9_pkg::TAPS) return gb9_pkg::TAPS;
         if (height_reg > gb9_pkg::MAX_HEIGHT) return gb9_pkg::MAX_HEIGHT;
         return height_reg;
      endfunction

      function bit [gb9_pkg::COEF_W-1:0] kernel_weight(int pos);
         int d;
         d = pos - gb9_pkg::TAPS / 2;
         if (d < 0) d = -d;
         return weight[d];
      endfunction

      function void write_reg(logic [gb9_pkg::CSR_INDEX_W-1:0] idx,
                              logic [gb9_pkg::CSR_DATA_W-1:0] data);
         if (idx <= gb9_pkg::CSR_COEF_OFF4)
            weight[idx] = data[gb9_pkg::COEF_W-1:0];
         else if (idx == gb9_pkg::CSR_IMAGE_WIDTH)
            width_reg = data[gb9_pkg::WIDTH_W-1:0];
         else if (idx == gb9_pkg::CSR_IMAGE_HEIGHT)
            height_reg = data[gb9_pkg::HEIGHT_W-1:0];
      endfunction

      // Pixels still needed to finish the current frame and frames-1 more.
      function int pixels_left(int frames);
         int unsigned w, h, rest;
         w = eff_width();
         h = eff_height();
         rest = (col >= w - 1) ? 1 : w - col;
         if (row < h - 1) rest += (h - 1 - row) * w;
         return rest + (frames - 1) * w * h;
      endfunction

      function void note_pixel(gb9_pkg::pixel_type p);
         int unsigned w, h, c, slot;
         bit [gb9_pkg::ACC_W-1:0] sum;
         blur_beat_type beat;
         w = eff_width();
         h = eff_height();
         c = col % MAX_W;

         // Shift the window left, then load the new column from the line store.
         for (int r = 0; r < gb9_pkg::TAPS; r++)
            for (int k = 0; k < gb9_pkg::TAPS - 1; k++) win[r][k] = win[r][k + 1];
         for (int r = 0; r < gb9_pkg::STORE_ROWS; r++) begin
            slot = (row + r) % gb9_pkg::STORE_ROWS;
            win[r][gb9_pkg::TAPS-1] = line_mem[slot][c];
         end
         win[gb9_pkg::TAPS-1][gb9_pkg::TAPS-1] = p;
         line_mem[row % gb9_pkg::STORE_ROWS][c] = p;

         // A beat comes out once the window lies wholly inside the frame.
         if (row >= gb9_pkg::TAPS - 1 && col >= gb9_pkg::TAPS - 1) begin
            sum = '0;
            for (int r = 0; r < gb9_pkg::TAPS; r++)
               for (int k = 0; k < gb9_pkg::TAPS; k++)
                  sum += gb9_pkg::acc_type'(win[r][k]) *
                         gb9_pkg::acc_type'(kernel_weight(k)) *
                         gb9_pkg::acc_type'(kernel_weight(r));
            beat.pix = sum[gb9_pkg::OUT_SHIFT +: gb9_pkg::PIXEL_W];
            beat.eof = (row >= h - 1 && col >= w - 1);
            expected_q.push_back(beat);
         end

         // Raster position; a shrunken geometry ends the row or frame early.
         if (col >= w - 1) begin
            col = 0;
            if (row >= h - 1) row = 0;
            else row++;
         end else begin
            col++;
         end
      endfunction

      function void check_beat(gb9_pkg::pixel_type pix, logic eof);
         blur_beat_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result beat: pixel_out %0d end_of_frame %0b", pix, eof);
            return;
         end
         want = expected_q.pop_front();
         if (pix !== want.pix || eof !== want.eof) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("beat %0d: expected pixel_out %0d end_of_frame %0b, got %0d %0b",
                        beats, want.pix, want.eof, pix, eof);
         end
         beats++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   gb9_req_if req_ch ();
   gb9_rsp_if rsp_ch ();
   gb9_csr_if csr_ch ();

   blur_scoreboard book = new();

   bit quiet        = 1'b0;
   bit hold_request = 1'b0;
   int idle_cycles  = 0;

   gaussian_blur_9x9_stream_core #(
      .MAX_WIDTH(MAX_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch),
      .csr_bus(csr_ch)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Gap lengths: mostly none or short, a few long; none in quiet stretches.
   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic gb9_pkg::pixel_type next_pixel(pattern_type kind, int k);
      case (kind)
         PAT_ZERO:    return 8'h00;
         PAT_MAX:     return 8'hFF;
         PAT_CHECKER: return k[0] ? 8'hFF : 8'h00;
         PAT_SPARSE:  return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
         default:     return 8'($urandom);
      endcase
   endfunction

   function automatic gb9_pkg::coef_type pick_weight();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'd255;
      return 8'($urandom);
   endfunction

   // Monitor: checks result beats first, then feeds accepted pixels and writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            book.check_beat(rsp_ch.pixel_out, rsp_ch.end_of_frame);
         if (req_ch.valid && req_ch.ready)
            book.note_pixel(req_ch.pixel_in);
         if (csr_ch.valid && csr_ch.ready)
            book.write_reg(csr_ch.index, csr_ch.data);
      end
   end

   // Watchdog: ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result receiver: random stalls, plus one long hold-off when requested.
   initial begin : rsp_receiver
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic write_csr(input logic [gb9_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [gb9_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Coefficient writes carry junk in the bits above the weight.
   task automatic set_weights(input gb9_pkg::coef_type c0, input gb9_pkg::coef_type c1,
                              input gb9_pkg::coef_type c2, input gb9_pkg::coef_type c3,
                              input gb9_pkg::coef_type c4);
      write_csr(gb9_pkg::CSR_COEF_CENTER, {5'($urandom), c0});
      write_csr(gb9_pkg::CSR_COEF_OFF1,   {5'($urandom), c1});
      write_csr(gb9_pkg::CSR_COEF_OFF2,   {5'($urandom), c2});
      write_csr(gb9_pkg::CSR_COEF_OFF3,   {5'($urandom), c3});
      write_csr(gb9_pkg::CSR_COEF_OFF4,   {5'($urandom), c4});
   endtask

   task automatic set_geometry(input logic [gb9_pkg::CSR_DATA_W-1:0] raw_w,
                               input logic [gb9_pkg::CSR_DATA_W-1:0] raw_h);
      write_csr(gb9_pkg::CSR_IMAGE_WIDTH, raw_w);
      write_csr(gb9_pkg::CSR_IMAGE_HEIGHT, raw_h);
   endtask

   // Offers count pixels; valid stays high between back-to-back beats.
   task automatic send_pixels(input int count, input pattern_type kind);
      int gap;
      for (int k = 0; k < count; k++) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid    <= 1'b1;
         req_ch.pixel_in <= next_pixel(kind, k);
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
   endtask

   task automatic send_frames(input int frames, input pattern_type kind);
      send_pixels(book.pixels_left(frames), kind);
   endtask

   // Waits until every expected beat is back and the core has gone idle.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_pixels;
      int phase;
      int w;
      int h;
      int frames;
      int pick;
      pattern_type kind;

      req_ch.valid    = 1'b0;
      req_ch.pixel_in = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = '0;
      csr_ch.data     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame with the reset kernel and random pixels.
      set_geometry(13'd9, 13'd9);
      send_frames(1, PAT_RANDOM);
      settle();

      // Full-scale weights on saturated pixels: the window sum wraps past the
      // kept byte. Geometry below the minimum and a spare register index.
      set_weights(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      set_geometry(13'd0, 13'd8);
      write_csr(CSR_SPARE_INDEX, 13'h1FFF);
      send_frames(1, PAT_MAX);
      settle();

      // Center tap only on a checkerboard.
      set_weights(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
      set_geometry(13'd10, 13'd11);
      send_frames(1, PAT_CHECKER);
      settle();

      // Width past the row store saturates to the widest row; after one full
      // row the width drops so the frame finishes quickly.
      set_weights(8'd67, 8'd54, 8'd27, 8'd9, 8'd1);
      set_geometry(13'h1FFF, 13'd9);
      send_pixels(MAX_W + 10, PAT_RANDOM);
      settle();
      write_csr(gb9_pkg::CSR_IMAGE_WIDTH, 13'd9);
      send_frames(1, PAT_RANDOM);
      settle();

      // Height past the limit saturates: rows go on past the ninth until a
      // smaller height ends the frame.
      set_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight(), pick_weight());
      set_geometry(13'd9, 13'h1FFF);
      send_pixels(10 * 9, PAT_RANDOM);
      settle();
      write_csr(gb9_pkg::CSR_IMAGE_HEIGHT, 13'd9);
      send_frames(1, PAT_RANDOM);
      settle();

      // Geometry shrunk mid-frame: the row, then the frame, end early.
      set_geometry(13'd12, 13'd16);
      send_pixels(10 * 12 + 10, PAT_RANDOM);
      settle();
      write_csr(gb9_pkg::CSR_IMAGE_WIDTH, 13'd10);
      send_pixels(1 + 2 * 10, PAT_RANDOM);
      settle();
      write_csr(gb9_pkg::CSR_IMAGE_HEIGHT, 13'd12);
      send_frames(1, PAT_RANDOM);
      settle();

      // Random frames of small shapes with fresh weights now and then.
      random_pixels = 0;
      phase = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (phase == 0 || $urandom_range(0, 2) == 0)
            set_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                        pick_weight());
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 18);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 14);
         frames = $urandom_range(1, 2);
         // The first phase has two beats per output row, so a held-off
         // receiver leaves a beat waiting and the core refuses pixels.
         if (phase == 0) begin
            w = 10;
            h = 10;
            frames = 1;
         end
         set_geometry({3'($urandom), 10'(w)}, 13'(h));
         pick = $urandom_range(0, 9);
         kind = (pick < 7) ? PAT_RANDOM : (pick == 7) ? PAT_SPARSE :
                (pick == 8) ? PAT_MAX : PAT_CHECKER;
         quiet = ($urandom_range(0, 3) == 0);
         // One phase keeps offering pixels while the receiver holds off.
         if (phase == 0) begin
            quiet = 1'b1;
            hold_request = 1'b1;
         end
         random_pixels += book.pixels_left(frames);
         send_frames(frames, kind);
         settle();
         quiet = 1'b0;
         phase++;
      end

      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
